// ===== src/discard_block_coalescer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Discard block coalescer assertion macros
// Concurrent assertion forms used by the dbc_ctrl module.
// ----------------------------------------------------------------------------
`ifndef DISCARD_BLOCK_COALESCER_TOP_MACROS_SVH
`define DISCARD_BLOCK_COALESCER_TOP_MACROS_SVH

// same-cycle implication
`define DBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbc assertion failed");

// next-cycle implication
`define DBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbc assertion failed");

`endif

// ===== src/dbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Discard block coalescer package
// Payload types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dbc_pkg;

  localparam int unsigned DBC_MAX_BLOCKS = 16;

  localparam logic [1:0] ACT_DISCARD = 2'd0;
  localparam logic [1:0] ACT_SEND    = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic CFG_BACKOFF = 1'b0;
  localparam logic CFG_STOPPED = 1'b1;

  localparam logic [15:0] BACKOFF_RESET = 16'd10;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] seq_num;
    logic        retx;
  } dbc_in_t;

  typedef struct packed {
    logic        kind;
    logic        retx_out;
    logic        has_block;
    logic [31:0] block_start;
    logic [31:0] block_len;
    logic        last;
  } dbc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic disc;
    logic tick;
    logic tmr_stop;
    logic start_emit;
    logic kind;
    logic rd;
    logic ld_blk;
    logic ld_empty;
    logic emit_done;
  } dbc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] action;
    logic       stopped;
    logic       cnt_zero;
    logic       extend;
    logic       new_fills;
    logic       tmr_running;
    logic       tmr_expire;
    logic       emit_last;
    logic       out_free;
  } dbc_sts_t;

endpackage

// ===== src/dbc_datapath.sv =====
// ----------------------------------------------------------------------------
// Discard block coalescer datapath
// Config registers, block memory, block count, backoff timer, output register.
// ----------------------------------------------------------------------------
module dbc_datapath import dbc_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = DBC_MAX_BLOCKS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dbc_in_t   in_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output dbc_out_t  out_data_o,
  input  dbc_cmd_t  cmd_i,
  output dbc_sts_t  sts_o
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  dbc_in_t     item_q;
  logic [15:0] backoff_q;
  logic        stopped_q;
  logic [CW-1:0] count_q, count_d;
  logic [31:0] last_start_q, last_start_d;
  logic [31:0] last_len_q, last_len_d;
  logic        running_q, running_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [IW-1:0] idx_q, idx_d;
  logic        msg_kind_q;
  logic        msg_retx_q;
  logic        out_valid_q, out_valid_d;
  dbc_out_t    out_q, out_d;

  logic [63:0] mem_q [MAX_BLOCKS];
  logic [63:0] rdata_q;
  logic        we;
  logic [IW-1:0] waddr;
  logic [63:0] wdata;

  logic [15:0] elapsed_inc;
  logic [31:0] last_end;

  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign last_end    = last_start_q + last_len_q;

  always_comb begin
    sts_o.action      = item_q.action;
    sts_o.stopped     = stopped_q;
    sts_o.cnt_zero    = (count_q == '0);
    sts_o.extend      = (last_end == item_q.seq_num);
    sts_o.new_fills   = (count_q == CW'(MAX_BLOCKS - 1));
    sts_o.tmr_running = running_q;
    sts_o.tmr_expire  = (elapsed_inc >= backoff_q);
    sts_o.emit_last   = ((CW'(idx_q) + CW'(1)) == count_q);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // block list update on a discard; the list is cleared when a message is done
  always_comb begin
    count_d      = count_q;
    last_start_d = last_start_q;
    last_len_d   = last_len_q;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    if (cmd_i.disc) begin
      we = 1'b1;
      if (count_q == '0) begin
        waddr        = '0;
        wdata        = {item_q.seq_num, 32'd1};
        last_start_d = item_q.seq_num;
        last_len_d   = 32'd1;
        count_d      = CW'(1);
      end else if (sts_o.extend) begin
        waddr      = IW'(count_q - CW'(1));
        wdata      = {last_start_q, last_len_q + 32'd1};
        last_len_d = last_len_q + 32'd1;
      end else begin
        waddr        = count_q[IW-1:0];
        wdata        = {item_q.seq_num, 32'd1};
        last_start_d = item_q.seq_num;
        last_len_d   = 32'd1;
        count_d      = count_q + CW'(1);
      end
    end
    if (cmd_i.emit_done) begin
      count_d = '0;
    end
  end

  always_comb begin
    running_d = running_q;
    elapsed_d = elapsed_q;
    if (cmd_i.disc && !running_q) begin
      running_d = 1'b1;
      elapsed_d = '0;
    end
    if (cmd_i.tick) begin
      elapsed_d = elapsed_inc;
    end
    if (cmd_i.tmr_stop) begin
      running_d = 1'b0;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (cmd_i.ld_blk) begin
      out_valid_d       = 1'b1;
      out_d.kind        = msg_kind_q;
      out_d.retx_out    = msg_retx_q;
      out_d.has_block   = 1'b1;
      out_d.block_start = rdata_q[63:32];
      out_d.block_len   = rdata_q[31:0];
      out_d.last        = sts_o.emit_last;
      idx_d             = idx_q + IW'(1);
    end
    if (cmd_i.ld_empty) begin
      out_valid_d       = 1'b1;
      out_d.kind        = KIND_DATA;
      out_d.retx_out    = item_q.retx;
      out_d.has_block   = 1'b0;
      out_d.block_start = '0;
      out_d.block_len   = '0;
      out_d.last        = 1'b1;
    end
    if (cmd_i.emit_done || cmd_i.start_emit) begin
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backoff_q   <= BACKOFF_RESET;
      stopped_q   <= 1'b0;
      count_q     <= '0;
      running_q   <= 1'b0;
      elapsed_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_idx_i == CFG_BACKOFF) begin
          backoff_q <= cfg_data_i;
        end else begin
          stopped_q <= cfg_data_i[0];
        end
      end
      count_q     <= count_d;
      running_q   <= running_d;
      elapsed_q   <= elapsed_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.start_emit) begin
      msg_kind_q <= cmd_i.kind;
      msg_retx_q <= (cmd_i.kind == KIND_FLUSH) ? 1'b0 : item_q.retx;
    end
    last_start_q <= last_start_d;
    last_len_q   <= last_len_d;
    out_q        <= out_d;
  end

  // block store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/dbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Discard block coalescer controller
// Sequences request decode, block list update and message readout.
// ----------------------------------------------------------------------------
`include "discard_block_coalescer_top_macros.svh"

module dbc_ctrl import dbc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dbc_sts_t sts_i,
  output dbc_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        unique case (sts_i.action)
          ACT_DISCARD: begin
            cmd_o.disc = 1'b1;
            // opening a block in the last free slot flushes, stopped or not
            if (!sts_i.cnt_zero && !sts_i.extend && sts_i.new_fills) begin
              cmd_o.tmr_stop   = 1'b1;
              cmd_o.start_emit = 1'b1;
              cmd_o.kind       = KIND_FLUSH;
              state_d          = ST_READ;
            end
          end
          ACT_SEND: begin
            if (!sts_i.stopped) begin
              cmd_o.tmr_stop = 1'b1;
              if (sts_i.cnt_zero) begin
                state_d = ST_EMPTY;
              end else begin
                cmd_o.start_emit = 1'b1;
                cmd_o.kind       = KIND_DATA;
                state_d          = ST_READ;
              end
            end
          end
          ACT_TICK: begin
            if (sts_i.tmr_running) begin
              cmd_o.tick = 1'b1;
              if (sts_i.tmr_expire) begin
                cmd_o.tmr_stop = 1'b1;
                if (!sts_i.stopped && !sts_i.cnt_zero) begin
                  cmd_o.start_emit = 1'b1;
                  cmd_o.kind       = KIND_FLUSH;
                  state_d          = ST_READ;
                end
              end
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.ld_blk = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.emit_done = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.ld_empty = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `DBC_ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_EXEC)
  `DBC_ASSERT_IMPL(a_load_after_read, clk_i, rst_ni, state_q == ST_LOAD, $past(state_q) == ST_READ || $past(state_q) == ST_LOAD)
  `DBC_ASSERT_IMPL(a_empty_after_exec, clk_i, rst_ni, state_q == ST_EMPTY, $past(state_q) == ST_EXEC || $past(state_q) == ST_EMPTY)

endmodule

// ===== src/discard_block_coalescer_top.sv =====
// ----------------------------------------------------------------------------
// Discard block coalescer top level
// Gathers discarded sequence numbers into blocks and emits them as messages.
// ----------------------------------------------------------------------------
// A request is captured when it is taken and decoded in the next cycle. A
// message is sent as a sequence of blocks: each block is one read of the
// block memory followed by a load of the output register. A send with no
// pending blocks loads a single message with no block instead. Each load
// waits while the output register is full and not taken.
// Configuration writes are taken in any cycle.
module discard_block_coalescer_top import dbc_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = DBC_MAX_BLOCKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dbc_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output dbc_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  dbc_cmd_t cmd;
  dbc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dbc_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
